// File: sv/fxalu_pkg.sv
// package for the signed fixed-point alu: operation codes and field widths
// no dependencies
package fxalu_pkg;

    localparam int unsigned DataWidth      = 32;
    localparam int unsigned ModeWidth      = 4;
    localparam int unsigned FractionBitsDefault = 8;

    typedef enum logic [ModeWidth-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MIN  = 4'd4,
        OP_MAX  = 4'd5,
        OP_INC  = 4'd6,
        OP_DEC  = 4'd7,
        OP_TOINT = 4'd8,
        OP_CMP  = 4'd9
    } op_t;

    // flags produced for every request
    typedef struct packed {
        logic a_less;
        logic a_equal;
        logic a_greater;
        logic divide_error;
    } flags_t;

endpackage

// File: sv/fxalu_div.sv
// pipelined restoring divider on magnitudes, one quotient bit per stage
// depends on fxalu_pkg
module fxalu_div #(
    parameter int unsigned NumWidth = 40,
    parameter int unsigned DenWidth = 32,
    parameter int unsigned TagWidth = 8
) (
    input  logic                aclk,
    input  logic                enable,
    input  logic [NumWidth-1:0] numerator,
    input  logic [DenWidth-1:0] denominator,
    input  logic [TagWidth-1:0] tag_in,
    output logic [NumWidth-1:0] quotient,
    output logic [TagWidth-1:0] tag_out
);
    import fxalu_pkg::*;

    localparam int unsigned RemWidth = DenWidth + 1;

    logic [NumWidth-1:0] num_reg [NumWidth+1];
    logic [RemWidth-1:0] rem_reg [NumWidth+1];
    logic [DenWidth-1:0] den_reg [NumWidth+1];
    logic [TagWidth-1:0] tag_reg [NumWidth+1];

    // stage zero input
    always_comb begin
        num_reg[0] = numerator;
        rem_reg[0] = '0;
        den_reg[0] = denominator;
        tag_reg[0] = tag_in;
    end

    // one quotient bit per stage, msb first
    for (genvar i = 0; i < NumWidth; i++) begin : g_stage
        logic [RemWidth-1:0] trial;
        logic [RemWidth:0]   diff;
        assign trial = {rem_reg[i][RemWidth-2:0], num_reg[i][NumWidth-1]};
        assign diff  = {1'b0, trial} - {2'b00, den_reg[i]};
        always_ff @(posedge aclk) begin
            if (enable) begin
                if (!diff[RemWidth]) begin
                    rem_reg[i+1] <= diff[RemWidth-1:0];
                    num_reg[i+1] <= {num_reg[i][NumWidth-2:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= trial;
                    num_reg[i+1] <= {num_reg[i][NumWidth-2:0], 1'b0};
                end
                den_reg[i+1] <= den_reg[i];
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign quotient = num_reg[NumWidth];
    assign tag_out  = tag_reg[NumWidth];

endmodule

// File: sv/fixed_point_q24_8_alu.sv
// signed fixed-point alu, stream in and out, one request per cycle while the output is not stalled
// pipeline: setup register, magnitude divider one bit per stage, output register
// throughput: one request per cycle unless the output stalls; the divider pipeline sets the depth
// the whole pipeline advances together and holds while the output waits
// reset: aresetn synchronous active low clears all valid bits
// depends on fxalu_pkg and fxalu_div
module fixed_point_q24_8_alu #(
    parameter int unsigned FRACTION_BITS = fxalu_pkg::FractionBitsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] mode, [35:4] operand_a, [67:36] operand_b, zero fill to 72
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] value, [32] a_less, [33] a_equal, [34] a_greater, [35] divide_error
    output logic [39:0] m_tdata
);
    import fxalu_pkg::*;

    localparam int unsigned NumWidth = DataWidth + FRACTION_BITS;
    localparam int unsigned Depth    = NumWidth + 2;
    // tag: value of non-divide ops, flags, mode, result sign
    localparam int unsigned TagWidth = DataWidth + 4 + ModeWidth + 1;

    logic advance;

    // ---------------- stage 1: decode, compare, simple ops, divider operands
    logic [ModeWidth-1:0]        mode;
    logic signed [DataWidth-1:0] op_a, op_b;
    assign mode = s_tdata[ModeWidth-1:0];
    assign op_a = s_tdata[ModeWidth +: DataWidth];
    assign op_b = s_tdata[ModeWidth+DataWidth +: DataWidth];

    logic [Depth-1:0] valid_reg;
    assign advance  = !valid_reg[Depth-1] || m_tready;
    assign s_tready = advance;

    flags_t                flags_s1;
    logic [DataWidth-1:0]  simple_s1;
    logic [DataWidth-1:0]  abs_a, abs_b;
    logic [NumWidth-1:0]   div_num;

    always_comb begin
        flags_s1.a_less       = op_a < op_b;
        flags_s1.a_equal      = op_a == op_b;
        flags_s1.a_greater    = op_a > op_b;
        flags_s1.divide_error = (mode == OP_DIV) && (op_b == '0);
        unique case (mode)
            OP_ADD:   simple_s1 = op_a + op_b;
            OP_SUB:   simple_s1 = op_a - op_b;
            OP_MIN:   simple_s1 = flags_s1.a_less ? op_a : op_b;
            OP_MAX:   simple_s1 = flags_s1.a_greater ? op_a : op_b;
            OP_INC:   simple_s1 = op_a + DataWidth'(1);
            OP_DEC:   simple_s1 = op_a - DataWidth'(1);
            default:  simple_s1 = '0;
        endcase
        abs_a   = op_a[DataWidth-1] ? DataWidth'(-op_a) : op_a;
        abs_b   = op_b[DataWidth-1] ? DataWidth'(-op_b) : op_b;
        div_num = {abs_a, {FRACTION_BITS{1'b0}}};
    end

    // registered stage 1
    logic [DataWidth-1:0]       simple_reg;
    flags_t                     flags_reg;
    logic [ModeWidth-1:0]       mode_reg;
    logic signed [DataWidth-1:0] a_reg, b_reg;
    logic [NumWidth-1:0]        num_reg;
    logic [DataWidth-1:0]       den_reg;
    logic                       neg_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            simple_reg <= simple_s1;
            flags_reg  <= flags_s1;
            mode_reg   <= mode;
            a_reg      <= op_a;
            b_reg      <= op_b;
            num_reg    <= div_num;
            den_reg    <= abs_b;
            neg_reg    <= op_a[DataWidth-1] ^ op_b[DataWidth-1];
        end
    end

    // ---------------- stage 2: multiply, truncating scale, to_int
    logic signed [2*DataWidth-1:0] prod;
    logic signed [2*DataWidth-1:0] prod_adj;
    logic signed [DataWidth-1:0]   toint_adj;
    logic [DataWidth-1:0]          value_s2;
    assign prod = a_reg * b_reg;

    always_comb begin
        // bias negatives so the arithmetic shift truncates toward zero
        prod_adj  = prod + (prod[2*DataWidth-1] ?
                    (2*DataWidth)'((64'd1 << FRACTION_BITS) - 64'd1) : '0);
        toint_adj = a_reg + (a_reg[DataWidth-1] ?
                    DataWidth'((32'd1 << FRACTION_BITS) - 32'd1) : '0);
        unique case (mode_reg)
            OP_MUL:   value_s2 = DataWidth'(prod_adj >>> FRACTION_BITS);
            OP_TOINT: value_s2 = DataWidth'(toint_adj >>> FRACTION_BITS);
            default:  value_s2 = simple_reg;
        endcase
    end

    // ---------------- divider stages carry the rest of the request
    logic [TagWidth-1:0] tag_in, tag_out;
    logic [NumWidth-1:0] quot;
    assign tag_in = {neg_reg, mode_reg, flags_reg, value_s2};

    fxalu_div #(
        .NumWidth (NumWidth),
        .DenWidth (DataWidth),
        .TagWidth (TagWidth)
    ) u_div (
        .aclk        (aclk),
        .enable      (advance),
        .numerator   (num_reg),
        .denominator (den_reg),
        .tag_in      (tag_in),
        .quotient    (quot),
        .tag_out     (tag_out)
    );

    // ---------------- output stage: sign fix and select
    flags_t               flags_o;
    logic [ModeWidth-1:0] mode_o;
    logic                 neg_o;
    logic [DataWidth-1:0] value_o, qlow;
    assign {neg_o, mode_o, flags_o, value_o} = tag_out;
    assign qlow = quot[DataWidth-1:0];

    logic [DataWidth-1:0] value_reg, value_next;
    flags_t               out_flags_reg;
    always_comb begin
        if (mode_o == OP_DIV)
            value_next = flags_o.divide_error ? '0 : (neg_o ? DataWidth'(-qlow) : qlow);
        else
            value_next = value_o;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            value_reg     <= value_next;
            out_flags_reg <= flags_o;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[Depth-2:0], s_tvalid};
        end
    end

    assign m_tvalid = valid_reg[Depth-1];
    assign m_tdata  = {4'b0000, out_flags_reg.divide_error, out_flags_reg.a_greater,
                       out_flags_reg.a_equal, out_flags_reg.a_less, value_reg};

    // checks
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("held result changed");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[32] && m_tdata[34]))
        else $error("less and greater both set");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones(m_tdata[34:32]) == 1)
        else $error("compare flags not exclusive");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[35] |-> m_tdata[31:0] == '0)
        else $error("divide error with nonzero value");

endmodule
